### rtl/aes128_block_cipher_core_macros.svh
// ----------------------------------------------------------------------------
// AES-128 core assertion macros
// Shorthand for the concurrent checks of the cipher core.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES128_BLOCK_CIPHER_CORE_MACROS_SVH

// Overlapping implication, disabled during reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AES_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Types, tables and byte-level round functions shared by the cipher modules.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int LATENCY    = NUM_ROUNDS + 1;

   typedef logic [127:0] state_type;
   typedef logic [3:0]   round_idx_type;

   typedef struct packed {
      logic      valid;
      logic      kind;
      state_type state;
   } lane_type;

   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;
   localparam logic KIND_ENCRYPT = 1'b0;

   localparam logic [2047:0] SBOX_VEC = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_VEC = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_VEC[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_VEC[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
      logic [7:0] p;
      logic [7:0] v;
      p = 8'h00;
      v = a;
      for (int i = 0; i < 4; i++) begin
         if (m[i]) begin
            p = p ^ v;
         end
         v = xtime(v);
      end
      return p;
   endfunction

   function automatic logic [7:0] get_byte(input state_type s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic state_type sub_bytes(input state_type s, input logic dec);
      state_type o;
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = dec ? inv_sbox(get_byte(s, i)) : sbox(get_byte(s, i));
      end
      return o;
   endfunction

   function automatic state_type shift_rows(input state_type s, input logic dec);
      state_type o;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            o[127 - 8 * (r * 4 + c) -: 8] = dec ? get_byte(s, r * 4 + ((c + 4 - r) % 4))
                                                : get_byte(s, r * 4 + ((c + r) % 4));
         end
      end
      return o;
   endfunction

   function automatic state_type mix_columns(input state_type s, input logic dec);
      state_type  o;
      logic [3:0] m [4];
      logic [7:0] v;
      if (dec) begin
         m = '{4'he, 4'hb, 4'hd, 4'h9};
      end else begin
         m = '{4'h2, 4'h3, 4'h1, 4'h1};
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int j = 0; j < 4; j++) begin
               v = v ^ gmul(get_byte(s, j * 4 + c), m[(j - r + 4) % 4]);
            end
            o[127 - 8 * (r * 4 + c) -: 8] = v;
         end
      end
      return o;
   endfunction

   function automatic state_type key_next(input state_type k, input logic [7:0] rcon);
      state_type  o;
      logic [7:0] t [4];
      for (int r = 0; r < 4; r++) begin
         t[r] = sbox(get_byte(k, ((r + 1) % 4) * 4 + 3));
      end
      t[0] = t[0] ^ rcon;
      for (int r = 0; r < 4; r++) begin
         o[127 - 8 * (r * 4) -: 8] = get_byte(k, r * 4) ^ t[r];
         for (int c = 1; c < 4; c++) begin
            o[127 - 8 * (r * 4 + c) -: 8] = get_byte(k, r * 4 + c)
                                          ^ o[127 - 8 * (r * 4 + c - 1) -: 8];
         end
      end
      return o;
   endfunction

endpackage

### rtl/aes128_block_cipher_core.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// Unrolled pipeline of ten round cells with a precomputed key schedule.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// req       in         start, busy         req_kind, req_block_high, req_block_low
// rsp       out        rsp_valid strobe    rsp_result_high, rsp_result_low
// csr       in         csr_valid, csr_ready csr_index, csr_wdata
//
// A word is accepted every cycle while busy is low; its result passes through
// one registered key-add stage and then ten registered round cells.
// After reset and after every key write, the round keys are expanded one key
// per cycle; busy is high and csr_ready low during that time.
// The result strobe cannot be stalled, so the pipeline never stops.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   aes_pkg::state_type round_keys [aes_pkg::NUM_ROUNDS + 1];
   aes_pkg::lane_type  lanes [aes_pkg::NUM_ROUNDS + 1];
   aes_pkg::lane_type  entry_ff;
   logic               running;
   logic               accept;

   assign busy      = running || reset;
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   aes_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (csr_valid && csr_ready),
      .wr_index   (csr_index),
      .wr_data    (csr_wdata),
      .running    (running),
      .round_keys (round_keys)
   );

   always_ff @(posedge clock) begin
      entry_ff.kind  <= req_kind;
      entry_ff.state <= {req_block_high, req_block_low}
                      ^ ((req_kind == aes_pkg::KIND_ENCRYPT) ? round_keys[0]
                                                             : round_keys[aes_pkg::NUM_ROUNDS]);
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= accept;
      end
   end

   assign lanes[0] = entry_ff;

   for (genvar i = 1; i <= aes_pkg::NUM_ROUNDS; i++) begin : g_cell
      aes_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .last     (i == aes_pkg::NUM_ROUNDS),
         .enc_key  (round_keys[i]),
         .dec_key  (round_keys[aes_pkg::NUM_ROUNDS - i]),
         .lane_in  (lanes[i - 1]),
         .lane_out (lanes[i])
      );
   end

   assign rsp_valid       = lanes[aes_pkg::NUM_ROUNDS].valid;
   assign rsp_result_high = lanes[aes_pkg::NUM_ROUNDS].state[127:64];
   assign rsp_result_low  = lanes[aes_pkg::NUM_ROUNDS].state[63:0];

endmodule

### rtl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Holds the key registers and expands the round keys, one per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic                  wr_index,
   input  logic [63:0]           wr_data,
   output logic                  running,
   output aes_pkg::state_type    round_keys [aes_pkg::NUM_ROUNDS + 1]
);

   logic [63:0]            key_high_ff, key_high_in;
   logic [63:0]            key_low_ff, key_low_in;
   logic                   running_ff, running_in;
   aes_pkg::round_idx_type cnt_ff, cnt_in;
   logic [7:0]             rcon_ff, rcon_in;
   aes_pkg::state_type     work_ff, work_in;
   aes_pkg::state_type     rk_ff [1:aes_pkg::NUM_ROUNDS];
   aes_pkg::state_type     next_key;

   assign next_key = aes_pkg::key_next(work_ff, rcon_ff);

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      running_in  = running_ff;
      cnt_in      = cnt_ff;
      rcon_in     = rcon_ff;
      work_in     = work_ff;
      if (wr_en) begin
         if (wr_index == aes_pkg::CSR_KEY_HIGH) begin
            key_high_in = wr_data;
         end else begin
            key_low_in = wr_data;
         end
         work_in    = (wr_index == aes_pkg::CSR_KEY_HIGH) ? {wr_data, key_low_ff}
                                                          : {key_high_ff, wr_data};
         running_in = 1'b1;
         cnt_in     = 4'd1;
         rcon_in    = 8'h01;
      end else if (running_ff) begin
         work_in    = next_key;
         rcon_in    = aes_pkg::xtime(rcon_ff);
         cnt_in     = cnt_ff + 4'd1;
         running_in = (cnt_ff != aes_pkg::round_idx_type'(aes_pkg::NUM_ROUNDS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         running_ff  <= 1'b1;
         cnt_ff      <= 4'd1;
         rcon_ff     <= 8'h01;
         work_ff     <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         running_ff  <= running_in;
         cnt_ff      <= cnt_in;
         rcon_ff     <= rcon_in;
         work_ff     <= work_in;
      end
   end

   for (genvar i = 1; i <= aes_pkg::NUM_ROUNDS; i++) begin : g_rk
      always_ff @(posedge clock) begin
         if (running_ff && !wr_en && cnt_ff == aes_pkg::round_idx_type'(i)) begin
            rk_ff[i] <= next_key;
         end
      end
      assign round_keys[i] = rk_ff[i];
   end

   assign round_keys[0] = {key_high_ff, key_low_ff};
   assign running       = running_ff;

endmodule

### rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES-128 round cell
// One registered cipher or inverse cipher round, passing the word onward.
// ----------------------------------------------------------------------------
module aes_round_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               last,
   input  aes_pkg::state_type enc_key,
   input  aes_pkg::state_type dec_key,
   input  aes_pkg::lane_type  lane_in,
   output aes_pkg::lane_type  lane_out
);

   aes_pkg::lane_type  lane_ff, lane_in_r;
   aes_pkg::state_type enc_s, dec_s;

   always_comb begin
      enc_s = aes_pkg::shift_rows(aes_pkg::sub_bytes(lane_in.state, 1'b0), 1'b0);
      if (!last) begin
         enc_s = aes_pkg::mix_columns(enc_s, 1'b0);
      end
      enc_s = enc_s ^ enc_key;
      dec_s = aes_pkg::sub_bytes(aes_pkg::shift_rows(lane_in.state, 1'b1), 1'b1) ^ dec_key;
      if (!last) begin
         dec_s = aes_pkg::mix_columns(dec_s, 1'b1);
      end
      lane_in_r       = lane_in;
      lane_in_r.state = (lane_in.kind == aes_pkg::KIND_ENCRYPT) ? enc_s : dec_s;
   end

   always_ff @(posedge clock) begin
      lane_ff.kind  <= lane_in_r.kind;
      lane_ff.state <= lane_in_r.state;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in_r.valid;
      end
   end

   assign lane_out = lane_ff;

endmodule

### rtl/aes_core_checker.sv
// ----------------------------------------------------------------------------
// AES-128 core port checker
// Checks pipeline latency and key schedule handshakes at the ports.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_core_macros.svh"

module aes_core_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   `AES_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, aes_pkg::LATENCY))
   `AES_ASSERT_IMP(a_req_gets_rsp, clock, reset, start && !busy, ##11 rsp_valid)
   `AES_ASSERT_NXT(a_csr_expands, clock, reset, csr_valid && csr_ready, busy && !csr_ready)

endmodule

bind aes128_block_cipher_core aes_core_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
